// ===== rtl/core/lphm_pkg.sv =====
// Shared types, constants and codes for the linear-probe hash map.
package lphm_pkg;

    localparam int CAPACITY    = 4096;
    localparam int SLOT_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS  = SLOT_BITS + 1;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 3;
    localparam int LIMIT_BITS  = 12;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 12'd2867;

    localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
    localparam int          MIX_SHIFT = 33;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_BITS   = PADDR_BITS - 2;

    typedef enum logic [REG_BITS-1:0] {
        REG_LOAD_LIMIT = 1'b0
    } t_reg_idx;

    typedef enum logic [0:0] {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_KEY_ZERO  = 3'd5
    } t_status;

    typedef struct packed {
        logic [0:0]            mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [VALUE_BITS-1:0]  value_out;
        logic [SLOT_BITS-1:0]   slot;
        logic [COUNT_BITS-1:0]  occupancy;
    } t_result;

    // Classified request as it waits between front and back
    typedef struct packed {
        logic [0:0]            mode;
        logic                  key_zero;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [SLOT_BITS-1:0]  home;
    } t_qent;

endpackage

// ===== rtl/core/linear_probe_hash_map.sv =====
// Top level of the linear-probe hash map: APB register, front, queue and back.
//
// Requests arrive on i_in (mode, key, value_in) under i_in_valid / o_in_ready
// and each produces exactly one word on o_out (status, value_out, slot,
// occupancy) under o_out_valid / i_out_ready, in request order.
// The front takes one request at a time and takes no new one until it has
// passed through capture and pre-mix, three 32x32 partial products, final
// mix to the home slot and hand-off to a two-deep queue, which waits while
// the queue is full. The back pops a request, probes one slot at a time on
// the registered table read, then loads the result register; key zero
// skips the probe. After reset the back sweeps the 4096-entry valid table,
// one slot per cycle, and o_in_ready stays low; APB writes are taken
// throughout. The load limit register sits at byte address 0 (reset 2867).
// A stalled result is held in the output register while the front keeps
// accepting and the queue fills; the back stops only when it has a new
// result and the output register is still occupied.
module linear_probe_hash_map (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lphm_pkg::t_req                      i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lphm_pkg::t_result                   o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lphm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [lphm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [lphm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);

    logic [lphm_pkg::LIMIT_BITS-1:0] r_load_limit;

    lphm_pkg::t_reg_idx reg_idx;
    logic               cfg_we;
    logic               clearing;
    logic               push;
    lphm_pkg::t_qent    push_ent;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    lphm_pkg::t_qent    q_head;

    assign pready  = 1'b1;
    assign reg_idx = lphm_pkg::t_reg_idx'(paddr[lphm_pkg::PADDR_BITS-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            lphm_pkg::REG_LOAD_LIMIT: prdata = lphm_pkg::PDATA_BITS'(r_load_limit);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_limit <= lphm_pkg::LIMIT_RESET;
        end else if (cfg_we && (reg_idx == lphm_pkg::REG_LOAD_LIMIT)) begin
            r_load_limit <= pwdata[lphm_pkg::LIMIT_BITS-1:0];
        end
    end

    lphm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clearing (clearing),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_push_ent (push_ent),
        .i_q_full   (q_full)
    );

    lphm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    lphm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_limit (r_load_limit),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_ready  (i_out_ready)
    );

endmodule

// ===== rtl/core/lphm_front.sv =====
// Front end: accepts requests, flags key zero and computes the home slot.
module lphm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clearing,
    input  logic                 i_in_valid,
    input  lphm_pkg::t_req       i_in,
    output logic                 o_in_ready,
    output logic                 o_push,
    output lphm_pkg::t_qent      o_push_ent,
    input  logic                 i_q_full
);

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_PUSH
    } t_fstate;

    localparam logic [31:0] MIX_LO = lphm_pkg::MIX_MULT[31:0];
    localparam logic [31:0] MIX_HI = lphm_pkg::MIX_MULT[63:32];

    t_fstate               r_state;
    lphm_pkg::t_qent       r_ent;
    logic [63:0]           r_x;
    logic [63:0]           r_p0;
    logic [31:0]           r_p1;
    logic [31:0]           r_p2;

    logic [63:0]           x_in;
    logic [63:0]           prod0;
    logic [31:0]           prod1;
    logic [31:0]           prod2;
    logic [63:0]           hsum;
    logic [63:0]           hmix;
    logic [lphm_pkg::SLOT_BITS-1:0] n_home;

    assign x_in  = i_in.key ^ (i_in.key >> lphm_pkg::MIX_SHIFT);
    // 64-bit product mod 2^64 from three 32x32 partial products
    assign prod0 = r_x[31:0] * MIX_LO;
    assign prod1 = r_x[63:32] * MIX_LO;
    assign prod2 = r_x[31:0] * MIX_HI;
    assign hsum  = r_p0 + {r_p1 + r_p2, 32'b0};
    assign hmix  = hsum ^ (hsum >> lphm_pkg::MIX_SHIFT);
    assign n_home = hmix[lphm_pkg::SLOT_BITS-1:0];

    assign o_in_ready = (r_state == F_IDLE) && !i_clearing;
    assign o_push     = (r_state == F_PUSH) && !i_q_full;
    assign o_push_ent = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_ent.mode     <= i_in.mode;
                        r_ent.key_zero <= (i_in.key == '0);
                        r_ent.key      <= i_in.key;
                        r_ent.value    <= i_in.value_in;
                        r_x            <= x_in;
                        r_state        <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_p0    <= prod0;
                    r_p1    <= prod1;
                    r_p2    <= prod2;
                    r_state <= F_SUM;
                end
                F_SUM: begin
                    r_ent.home <= n_home;
                    r_state    <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/lphm_queue.sv =====
// Short request queue between front and back.
module lphm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lphm_pkg::t_qent      i_push_ent,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output lphm_pkg::t_qent      o_head
);

    localparam logic [lphm_pkg::QPTR_BITS-1:0] LAST_PTR =
        lphm_pkg::QPTR_BITS'(lphm_pkg::QUEUE_DEPTH - 1);

    lphm_pkg::t_qent                 r_mem [lphm_pkg::QUEUE_DEPTH];
    logic [lphm_pkg::QPTR_BITS-1:0]  r_wp;
    logic [lphm_pkg::QPTR_BITS-1:0]  r_rp;
    logic [lphm_pkg::QCNT_BITS-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == lphm_pkg::QCNT_BITS'(lphm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/lphm_back.sv =====
// Back end: slot tables, valid clearing sweep, probe sequencer and result register.
module lphm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lphm_pkg::LIMIT_BITS-1:0]     i_load_limit,
    input  logic                                i_q_empty,
    input  lphm_pkg::t_qent                     i_q_head,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_out_valid,
    output lphm_pkg::t_result                   o_out,
    input  logic                                i_out_ready
);

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_DONE
    } t_bstate;

    localparam int SB = lphm_pkg::SLOT_BITS;
    localparam int CB = lphm_pkg::COUNT_BITS;
    localparam int VB = lphm_pkg::VALUE_BITS;

    logic                           mem_valid [lphm_pkg::CAPACITY];
    logic [lphm_pkg::KEY_BITS-1:0]  mem_key   [lphm_pkg::CAPACITY];
    logic [VB-1:0]                  mem_value [lphm_pkg::CAPACITY];

    t_bstate                        r_state;
    lphm_pkg::t_qent                r_ent;
    logic [SB-1:0]                  r_idx;
    logic [SB-1:0]                  r_n;
    logic [CB-1:0]                  r_count;
    lphm_pkg::t_status              r_status;
    logic [VB-1:0]                  r_value;
    logic [SB-1:0]                  r_slot;
    logic                           r_out_valid;
    lphm_pkg::t_result              r_out;
    logic                           r_rd_valid;
    logic [lphm_pkg::KEY_BITS-1:0]  r_rd_key;
    logic [VB-1:0]                  r_rd_value;

    logic [SB-1:0] n_rd_addr;
    logic          probing;
    logic          is_lookup;
    logic          hit;
    logic          at_limit;
    logic          ins_now;
    logic          vld_we;
    logic          out_free;
    logic          out_load;

    assign probing   = (r_state == B_PROBE);
    assign is_lookup = (r_ent.mode == lphm_pkg::MODE_LOOKUP);
    assign hit       = r_rd_valid && (r_rd_key == r_ent.key);
    assign at_limit  = (r_count >= CB'(i_load_limit));
    assign ins_now   = probing && !r_rd_valid && !is_lookup && !at_limit;
    assign vld_we    = (r_state == B_CLEAR) || ins_now;
    assign out_free  = !r_out_valid || i_out_ready;
    assign out_load  = (r_state == B_DONE) && out_free;

    // Read the home slot on pop, else the slot after the current one
    assign n_rd_addr = (r_state == B_IDLE) ? i_q_head.home : r_idx + 1'b1;

    assign o_pop       = (r_state == B_IDLE) && !i_q_empty;
    assign o_clearing  = (r_state == B_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (vld_we) begin
            mem_valid[r_idx] <= ins_now;
        end
        if (ins_now) begin
            mem_key[r_idx]   <= r_ent.key;
            mem_value[r_idx] <= r_ent.value;
        end
        r_rd_valid <= mem_valid[n_rd_addr];
        r_rd_key   <= mem_key[n_rd_addr];
        r_rd_value <= mem_value[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == '1) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_ent   <= i_q_head;
                        r_idx   <= i_q_head.home;
                        r_n     <= '0;
                        r_value <= '0;
                        r_slot  <= '0;
                        if (i_q_head.key_zero) begin
                            r_status <= lphm_pkg::ST_KEY_ZERO;
                            r_state  <= B_DONE;
                        end else begin
                            r_state <= B_PROBE;
                        end
                    end
                end
                B_PROBE: begin
                    if (!r_rd_valid) begin
                        // empty slot ends the probe
                        if (is_lookup) begin
                            r_status <= lphm_pkg::ST_NOT_FOUND;
                        end else if (at_limit) begin
                            r_status <= lphm_pkg::ST_FULL;
                        end else begin
                            r_status <= lphm_pkg::ST_INSERTED;
                            r_slot   <= r_idx;
                            r_count  <= r_count + 1'b1;
                        end
                        r_state <= B_DONE;
                    end else if (hit) begin
                        r_status <= is_lookup ? lphm_pkg::ST_FOUND : lphm_pkg::ST_PRESENT;
                        r_value  <= r_rd_value;
                        r_slot   <= r_idx;
                        r_state  <= B_DONE;
                    end else if (r_n == '1) begin
                        // every slot visited
                        r_status <= is_lookup ? lphm_pkg::ST_NOT_FOUND : lphm_pkg::ST_FULL;
                        r_state  <= B_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_n   <= r_n + 1'b1;
                    end
                end
                B_DONE: begin
                    if (out_free) begin
                        r_out.status    <= r_status;
                        r_out.value_out <= r_value;
                        r_out.slot      <= r_slot;
                        r_out.occupancy <= r_count;
                        r_state         <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/lphm_checker.sv =====
// Port-level checks for the linear-probe hash map, bound to the top level.
module lphm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input lphm_pkg::t_result    o_out
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // No stored value unless the key was met
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == lphm_pkg::ST_INSERTED ||
                        o_out.status == lphm_pkg::ST_NOT_FOUND ||
                        o_out.status == lphm_pkg::ST_FULL ||
                        o_out.status == lphm_pkg::ST_KEY_ZERO)
        |-> o_out.value_out == '0)
        else $error("value_out set without a key match");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == lphm_pkg::ST_NOT_FOUND ||
                        o_out.status == lphm_pkg::ST_FULL ||
                        o_out.status == lphm_pkg::ST_KEY_ZERO)
        |-> o_out.slot == '0)
        else $error("slot set without a placement or match");

    // A key that is stored implies a non-empty table
    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == lphm_pkg::ST_INSERTED ||
                        o_out.status == lphm_pkg::ST_PRESENT ||
                        o_out.status == lphm_pkg::ST_FOUND)
        |-> o_out.occupancy != '0)
        else $error("empty table reported with a stored key");

    // Refuse requests right after reset, as the valid table sweep begins; the rest of the sweep is not checked
    a_sweep_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken during clearing sweep");

endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);
